### sv/prc_pkg.sv
package prc_pkg;

  // Default number of micro-rotations (legal range 8 to 32)
  localparam int unsigned ITERATIONS_DEF = 24;

  // Fraction guard bits carried below Q16.16 in the datapath
  localparam int unsigned GUARD = 16;

  // Datapath widths: x/y in Q16.32 with growth headroom, angle in Q3.29 with wrap room
  localparam int unsigned XY_W = 50;
  localparam int unsigned Z_W  = 34;
  localparam int unsigned R_W  = XY_W - GUARD;

  // Action codes
  localparam logic ACT_TO_RECT  = 1'b0;
  localparam logic ACT_TO_POLAR = 1'b1;

  // CORDIC gain 1/An in Q1.30, pi and pi/2 in Q3.29
  localparam logic signed [30:0]    GAIN_Q30    = 31'sd652032874;
  localparam logic signed [Z_W-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [Z_W-1:0] HALF_PI_Q29 = 34'sd843314857;

  // atan(2^-i) in Q3.29, rounded to nearest
  localparam logic signed [Z_W-1:0] ATAN_Q29 [32] = '{
    34'sd421657428, 34'sd248918915, 34'sd131521918, 34'sd66762579,
    34'sd33510843,  34'sd16771758,  34'sd8387925,   34'sd4194219,
    34'sd2097141,   34'sd1048575,   34'sd524288,    34'sd262144,
    34'sd131072,    34'sd65536,     34'sd32768,     34'sd16384,
    34'sd8192,      34'sd4096,      34'sd2048,      34'sd1024,
    34'sd512,       34'sd256,       34'sd128,       34'sd64,
    34'sd32,        34'sd16,        34'sd8,         34'sd4,
    34'sd2,         34'sd1,         34'sd0,         34'sd0
  };

  // One pipeline slot of the rotation chain
  typedef struct packed {
    logic                  valid;
    logic                  mode;     // action code
    logic                  bypass;   // vectoring with y equal to zero
    logic                  byp_neg;  // x negative in the bypass case
    logic                  byp_sat;  // |x| clamped in the bypass case
    logic [31:0]           byp_mag;  // |x| in the bypass case
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } stage_t;

endpackage

### sv/prc_in_if.sv
interface prc_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;

  modport source (output valid, action, first_value, second_value, input ready);
  modport sink   (input valid, action, first_value, second_value, output ready);
endinterface

### sv/prc_out_if.sv
interface prc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_result;
  logic signed [31:0] second_result;
  logic               saturated;

  modport source (output valid, first_result, second_result, saturated, input ready);
  modport sink   (input valid, first_result, second_result, saturated, output ready);
endinterface

### sv/prc_cordic_stage.sv
module prc_cordic_stage import prc_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  stage_t stage_i,
  output stage_t stage_o
);

  localparam logic [4:0] IDX = 5'(SHIFT);

  logic signed [XY_W-1:0] xs, ys;
  logic                   sub;
  stage_t                 stage_d, stage_q;

  // Pick the rotation direction and apply one micro-rotation
  always_comb begin
    xs  = stage_i.x >>> SHIFT;
    ys  = stage_i.y >>> SHIFT;
    sub = (stage_i.mode == ACT_TO_POLAR) ? stage_i.y[XY_W-1] : !stage_i.z[Z_W-1];
    stage_d = stage_i;
    if (sub) begin
      stage_d.x = stage_i.x - ys;
      stage_d.y = stage_i.y + xs;
      stage_d.z = stage_i.z - ATAN_Q29[IDX];
    end else begin
      stage_d.x = stage_i.x + ys;
      stage_d.y = stage_i.y - xs;
      stage_d.z = stage_i.z + ATAN_Q29[IDX];
    end
  end

  // Advance the slot with the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### sv/polar_rect_convert_core.sv
// Channel  Modport            Moves per transaction
// in_i     prc_in_if.sink     action, first_value, second_value
// out_o    prc_out_if.source  first_result, second_result, saturated
//
// One transaction is accepted per cycle while out_o is not stalled; the registered stages are
// operand setup, gain multiply, one stage per micro-rotation and the output register.
// The pipeline depth is set by the ITERATIONS-long chain of rotation stages.
// Reset clears the valid bits and the rotation slots; the block is ready right after reset.
// A stall on out_o freezes the whole pipeline and in_i.ready drops with it.
module polar_rect_convert_core import prc_pkg::*; #(
  parameter int unsigned ITERATIONS = ITERATIONS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  prc_in_if.sink    in_i,
  prc_out_if.source out_o
);

  logic adv;

  // Operand setup stage signals
  logic signed [32:0]    a_ext, b_ext;
  logic signed [Z_W-1:0] b_z;
  logic signed [32:0]    pre_a_d, pre_b_d, pre_a_q, pre_b_q;
  logic signed [Z_W-1:0] pre_z_d, pre_z_q;
  logic                  pre_byp_d, pre_byp_q;
  logic                  pre_sat_d, pre_sat_q;
  logic [31:0]           pre_mag_d, pre_mag_q;
  logic                  pre_valid_q, pre_mode_q, pre_neg_q;

  // Gain multiply stage signals
  logic signed [63:0] prod_a, prod_b;
  stage_t             mul_d, mul_q;
  stage_t             chain [ITERATIONS+1];

  // Output stage signals
  stage_t                last;
  logic signed [XY_W-1:0] x_rnd, y_rnd;
  logic signed [R_W-1:0]  x_fin, y_fin;
  logic                   x_sat, y_sat;
  logic [31:0]            x_clip, y_clip;
  logic [31:0]            res1_d, res2_d;
  logic                   sat_d;
  logic                   out_valid_q;
  logic [31:0]            res1_q, res2_q;
  logic                   sat_q;

  localparam logic signed [R_W-1:0]  R_MAX = R_W'(64'sd2147483647);
  localparam logic signed [R_W-1:0]  R_MIN = R_W'(-64'sd2147483648);
  localparam logic signed [XY_W-1:0] RND   = XY_W'(64'sd1 <<< (GUARD - 1));

  // Advance the whole pipeline unless a finished result is held
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Reduce the quadrant, pick the starting angle and set up the bypass magnitude
  always_comb begin
    a_ext     = {in_i.first_value[31], in_i.first_value};
    b_ext     = {in_i.second_value[31], in_i.second_value};
    b_z       = Z_W'(b_ext);
    pre_a_d   = a_ext;
    pre_b_d   = b_ext;
    pre_z_d   = '0;
    pre_byp_d = 1'b0;
    pre_sat_d = 1'b0;
    pre_mag_d = in_i.first_value[31] ? 32'(-a_ext) : in_i.first_value;
    if (in_i.first_value == 32'h8000_0000) begin
      pre_mag_d = 32'h7FFF_FFFF;
      pre_sat_d = 1'b1;
    end
    if (in_i.action == ACT_TO_RECT) begin
      pre_z_d = b_z;
      if (b_z > HALF_PI_Q29) begin
        pre_z_d = b_z - PI_Q29;
        pre_a_d = -a_ext;
      end else if (b_z < -HALF_PI_Q29) begin
        pre_z_d = b_z + PI_Q29;
        pre_a_d = -a_ext;
      end
    end else if (in_i.second_value == 32'sd0) begin
      pre_byp_d = 1'b1;
    end else if (a_ext < 0) begin
      pre_z_d = (b_ext > 0) ? PI_Q29 : -PI_Q29;
      pre_a_d = -a_ext;
      pre_b_d = -b_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (adv) begin
      pre_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pre_mode_q <= in_i.action;
      pre_neg_q  <= in_i.first_value[31];
      pre_byp_q  <= pre_byp_d;
      pre_sat_q  <= pre_sat_d;
      pre_mag_q  <= pre_mag_d;
      pre_a_q    <= pre_a_d;
      pre_b_q    <= pre_b_d;
      pre_z_q    <= pre_z_d;
    end
  end

  // Prescale by the gain, round half up into Q16.32
  always_comb begin
    prod_a        = pre_a_q * GAIN_Q30 + 64'sd8192;
    prod_b        = pre_b_q * GAIN_Q30 + 64'sd8192;
    mul_d.valid   = pre_valid_q;
    mul_d.mode    = pre_mode_q;
    mul_d.bypass  = pre_byp_q;
    mul_d.byp_neg = pre_neg_q;
    mul_d.byp_sat = pre_sat_q;
    mul_d.byp_mag = pre_mag_q;
    mul_d.x       = prod_a[63:14];
    mul_d.y       = (pre_mode_q == ACT_TO_POLAR) ? prod_b[63:14] : '0;
    mul_d.z       = pre_z_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= '0;
    end else if (adv) begin
      mul_q <= mul_d;
    end
  end

  assign chain[0] = mul_q;

  // Micro-rotation chain, one stage per iteration
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_rot
    prc_cordic_stage #(
      .SHIFT (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .stage_i (chain[k]),
      .stage_o (chain[k+1])
    );
  end

  assign last = chain[ITERATIONS];

  // Round to Q16.16, clamp, and select the result fields
  always_comb begin
    x_rnd  = last.x + RND;
    y_rnd  = last.y + RND;
    x_fin  = x_rnd[XY_W-1:GUARD];
    y_fin  = y_rnd[XY_W-1:GUARD];
    x_sat  = (x_fin > R_MAX) || (x_fin < R_MIN);
    y_sat  = (y_fin > R_MAX) || (y_fin < R_MIN);
    x_clip = (x_fin > R_MAX) ? 32'h7FFF_FFFF :
             (x_fin < R_MIN) ? 32'h8000_0000 : x_fin[31:0];
    y_clip = (y_fin > R_MAX) ? 32'h7FFF_FFFF :
             (y_fin < R_MIN) ? 32'h8000_0000 : y_fin[31:0];
    if (last.mode == ACT_TO_RECT) begin
      res1_d = x_clip;
      res2_d = y_clip;
      sat_d  = x_sat || y_sat;
    end else if (last.bypass) begin
      res1_d = last.byp_mag;
      res2_d = last.byp_neg ? PI_Q29[31:0] : 32'h0;
      sat_d  = last.byp_sat;
    end else begin
      res1_d = x_clip;
      res2_d = last.z[31:0];
      sat_d  = x_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res1_q <= res1_d;
      res2_q <= res2_d;
      sat_q  <= sat_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.first_result  = res1_q;
  assign out_o.second_result = res2_q;
  assign out_o.saturated     = sat_q;

endmodule
